FILE: src/magic_length_frame_receiver_assert.svh
// assertion macros for the frame receiver
`ifndef MAGIC_LENGTH_FRAME_RECEIVER_ASSERT_SVH
`define MAGIC_LENGTH_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent holds in a cycle -> consequent holds in the same cycle
`define MLFR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame receiver check failed");
// antecedent holds in a cycle -> consequent holds in the next cycle
`define MLFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame receiver check failed");
`else
`define MLFR_ASSERT_SAME(label, clk, rst, ante, cons)
`define MLFR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: src/mlfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mlfr_pkg;

   localparam int unsigned ByteW   = 8;
   localparam int unsigned WordW   = 32;
   localparam int unsigned KindW   = 2;
   localparam int unsigned CsrIdxW = 8;
   localparam int unsigned TdataW  = ByteW + WordW;

   localparam logic [WordW-1:0] MagicReset  = 32'h4D49_4E49;  // ascii MINI
   localparam logic [WordW-1:0] MaxLenReset = 32'd65536;

   localparam logic [CsrIdxW-1:0] CsrMagicWord = 8'd0;
   localparam logic [CsrIdxW-1:0] CsrMaxLength = 8'd1;

   typedef enum logic [KindW-1:0] {
      KIND_DATA       = 2'd0,
      KIND_HEADER     = 2'd1,
      KIND_BAD_MAGIC  = 2'd2,
      KIND_BAD_LENGTH = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [ByteW-1:0]  data_byte;
      logic              last;
      logic [WordW-1:0]  header_word;
   } rsp_item_type;

endpackage

`default_nettype wire

FILE: src/magic_length_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  transfer contents
// req      in         one received byte
// rsp      out        payload byte, header report or error report
// csr      in         register write (0 magic word, 1 max length)
//
// one byte is taken per cycle; all decoding sits between the state registers
// and a two-entry output queue (output register plus skid register)
// a stalled rsp side is absorbed by the skid register; req_tready drops only
// while both entries hold results, so bytes that cause no result keep flowing
// reset is synchronous: hunting the magic word, counters cleared, defaults loaded
// csr writes are always taken and act on the next comparison

`include "magic_length_frame_receiver_assert.svh"

module magic_length_frame_receiver (
   input  wire                                    clock,
   input  wire                                    reset,
   // request byte stream
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   input  wire  [mlfr_pkg::ByteW-1:0]             req_tdata,   // [7:0] rx_byte
   // result stream
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   output logic [mlfr_pkg::TdataW-1:0]            rsp_tdata,   // [7:0] data_byte,
                                                               // [39:8] header_word
   output logic                                   rsp_tlast,   // last
   output logic [mlfr_pkg::KindW-1:0]             rsp_tuser,   // [1:0] kind
   // register write port
   input  wire                                    csr_valid,
   output logic                                   csr_ready,
   input  wire  [mlfr_pkg::CsrIdxW-1:0]           csr_index,
   input  wire  [mlfr_pkg::WordW-1:0]             csr_data
);

   import mlfr_pkg::*;

   typedef enum logic [1:0] {
      PH_MAGIC   = 2'd0,
      PH_LENGTH  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   // configuration
   logic [WordW-1:0] magic_word_ff;
   logic [WordW-1:0] max_length_ff;

   // deframer state
   phase_type        phase_ff,      phase_in;
   logic [1:0]       byte_index_ff, byte_index_in;
   logic [WordW-1:0] assembly_ff,   assembly_in;
   logic [WordW-1:0] bytes_left_ff, bytes_left_in;

   // output queue
   logic             out_valid_ff,  skid_valid_ff;
   rsp_item_type     out_ff,        skid_ff;

   logic             req_xfer;
   logic             rsp_xfer;
   logic             has_result;
   rsp_item_type     result;
   logic [WordW-1:0] gathered;
   logic             word_done;
   logic             last_byte;

   assign req_tready = !skid_valid_ff;
   assign csr_ready  = 1'b1;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = out_valid_ff && rsp_tready;

   assign gathered  = {assembly_ff[WordW-ByteW-1:0], req_tdata};
   assign word_done = (byte_index_ff == 2'd3);
   assign last_byte = (bytes_left_ff <= 32'd1);

   // decode of one byte
   always_comb begin
      phase_in      = phase_ff;
      byte_index_in = byte_index_ff;
      assembly_in   = assembly_ff;
      bytes_left_in = bytes_left_ff;
      has_result    = 1'b0;
      result        = '{kind: KIND_DATA, data_byte: '0, last: 1'b0, header_word: '0};

      unique case (phase_ff)
         PH_PAYLOAD: begin
            has_result       = 1'b1;
            result.data_byte = req_tdata;
            result.last      = last_byte;
            if (last_byte) begin
               bytes_left_in = '0;
               phase_in      = PH_MAGIC;
               byte_index_in = 2'd0;
            end else begin
               bytes_left_in = bytes_left_ff - 32'd1;
            end
         end
         PH_LENGTH: begin
            assembly_in   = gathered;
            byte_index_in = word_done ? 2'd0 : byte_index_ff + 2'd1;
            if (word_done) begin
               has_result         = 1'b1;
               result.header_word = gathered;
               if (gathered == '0 || gathered > max_length_ff) begin
                  result.kind = KIND_BAD_LENGTH;
                  phase_in    = PH_MAGIC;
               end else begin
                  result.kind   = KIND_HEADER;
                  bytes_left_in = gathered;
                  phase_in      = PH_PAYLOAD;
               end
            end
         end
         default: begin
            // hunting the magic word, also the unused phase code
            phase_in      = PH_MAGIC;
            assembly_in   = gathered;
            byte_index_in = word_done ? 2'd0 : byte_index_ff + 2'd1;
            if (word_done) begin
               if (gathered != magic_word_ff) begin
                  has_result         = 1'b1;
                  result.kind        = KIND_BAD_MAGIC;
                  result.header_word = gathered;
               end else begin
                  phase_in = PH_LENGTH;
               end
            end
         end
      endcase
   end

   // state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_word_ff <= MagicReset;
         max_length_ff <= MaxLenReset;
         phase_ff      <= PH_MAGIC;
         byte_index_ff <= 2'd0;
         assembly_ff   <= '0;
         bytes_left_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CsrMagicWord) begin
               magic_word_ff <= csr_data;
            end else if (csr_index == CsrMaxLength) begin
               max_length_ff <= csr_data;
            end
         end
         if (req_xfer) begin
            phase_ff      <= phase_in;
            byte_index_ff <= byte_index_in;
            assembly_ff   <= assembly_in;
            bytes_left_ff <= bytes_left_in;
         end
      end
   end

   // output register and skid register; a push only happens with the skid empty
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_xfer) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_xfer && has_result) begin
         if (!out_valid_ff || rsp_xfer) begin
            out_ff       <= result;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_xfer) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.header_word, out_ff.data_byte};
   assign rsp_tlast  = out_ff.last;
   assign rsp_tuser  = out_ff.kind;

   // skid entry never waits behind an empty output register
   `MLFR_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   // a payload phase always has bytes still to pass
   `MLFR_ASSERT_SAME(a_payload_count, clock, reset, phase_ff == PH_PAYLOAD,
                     bytes_left_ff != '0)
   // word gathering is aligned while payload passes
   `MLFR_ASSERT_SAME(a_payload_aligned, clock, reset, phase_ff == PH_PAYLOAD,
                     byte_index_ff == 2'd0)
   // the final payload byte ends the frame
   `MLFR_ASSERT_NEXT(a_last_ends_frame, clock, reset,
                     req_xfer && phase_ff == PH_PAYLOAD && last_byte,
                     phase_ff == PH_MAGIC)

endmodule

`default_nettype wire
